// ===== sv/cdpa_pkg.sv =====
`default_nettype none

package cdpa_pkg;

   localparam int unsigned REQ_DATA_W = 48;
   localparam int unsigned REQ_USER_W = 2;
   localparam int unsigned RSP_DATA_W = 32;

   // 400 years always hold the same number of days
   localparam logic [15:0] CYCLE_YEARS = 16'd400;
   localparam logic [19:0] CYCLE_DAYS  = 20'd146097;
   localparam logic [8:0]  YMOD_LAST   = 9'd399;
   localparam logic [15:0] YEAR_MAX    = 16'hFFFF;
   localparam logic [3:0]  MON_JAN     = 4'd1;
   localparam logic [3:0]  MON_FEB     = 4'd2;
   localparam logic [3:0]  MON_DEC     = 4'd12;

   // reciprocals for division by 400 and by 12
   localparam logic [16:0] RECIP_400 = 17'd83887;
   localparam logic [16:0] RECIP_12  = 17'd43691;

   typedef enum logic [1:0] {
      MODE_DAYS   = 2'd0,
      MODE_WEEKS  = 2'd1,
      MODE_MONTHS = 2'd2,
      MODE_YEARS  = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      OP_NONE      = 4'd0,
      OP_LOAD      = 4'd1,
      OP_MUL_YEAR  = 4'd2,
      OP_YMOD      = 4'd3,
      OP_SETUP     = 4'd4,
      OP_MUL_COUNT = 4'd5,
      OP_MDIV      = 4'd6,
      OP_SNAP      = 4'd7,
      OP_YSTEP     = 4'd8,
      OP_MSTEP     = 4'd9,
      OP_EMIT      = 4'd10
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic     start_ok;
      logic     zero_count;
      mode_type mode;
      logic     err;
      logic     year_fit;
      logic     month_fit;
   } sts_type;

   // leap year from the year modulo 400
   function automatic logic is_leap(input logic [8:0] ymod);
      return (ymod[1:0] == 2'b00) && (ymod != 9'd100) && (ymod != 9'd200) &&
             (ymod != 9'd300);
   endfunction

   function automatic logic [4:0] days_in(input logic [3:0] mon, input logic leap);
      logic [4:0] len;
      case (mon)
         MON_FEB: len = 5'd28 + {4'b0, leap};
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

   // days of the year before the first of the month
   function automatic logic [8:0] days_before(input logic [3:0] mon, input logic leap);
      logic [8:0] base;
      case (mon)
         4'd2:    base = 9'd31;
         4'd3:    base = 9'd59;
         4'd4:    base = 9'd90;
         4'd5:    base = 9'd120;
         4'd6:    base = 9'd151;
         4'd7:    base = 9'd181;
         4'd8:    base = 9'd212;
         4'd9:    base = 9'd243;
         4'd10:   base = 9'd273;
         4'd11:   base = 9'd304;
         4'd12:   base = 9'd334;
         default: base = 9'd0;
      endcase
      return base + {8'b0, leap && (mon > MON_FEB)};
   endfunction

endpackage

`default_nettype wire

// ===== sv/calendar_date_period_add.sv =====
// Shifts a Gregorian date by a signed count of days, weeks, months or years and
// returns the new date with a valid flag; an invalid start date or a result outside
// years 1 to 65535 comes back as 0/0/0 with the flag low. One request is worked at
// a time. A zero count or an invalid start goes from the start check straight to
// the result; a month shift divides the count by 12 and reduces the new year, a
// year shift reduces the new year, and both then snap the day if it is in range.
// A day or week shift walks one year (or a whole 400-year span) or one month per
// cycle through the datapath's day-count adders, years first, then the months of
// the final year. The next request is taken in the cycle after the result is loaded
// into the output register, even if that result is still waiting to be taken.
`default_nettype none

module calendar_date_period_add (
   input  wire  logic                              clock,
   input  wire  logic                              reset,
   input  wire  logic                              req_tvalid,
   output logic                                    req_tready,
   // count, in_day, in_month, in_year
   input  wire  logic [cdpa_pkg::REQ_DATA_W-1:0]   req_tdata,
   // mode
   input  wire  logic [cdpa_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                                    rsp_tvalid,
   input  wire  logic                              rsp_tready,
   // out_day, out_month, out_year
   output logic [cdpa_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   // date_ok
   output logic                                    rsp_tuser
);

   cdpa_pkg::cmd_type cmd;
   cdpa_pkg::sts_type sts;

   cdpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   cdpa_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== sv/cdpa_dp.sv =====
`default_nettype none

module cdpa_dp (
   input  wire  logic                                  clock,
   input  wire  logic                                  reset,
   input  wire  cdpa_pkg::cmd_type                     cmd,
   output cdpa_pkg::sts_type                           sts,
   input  wire  logic [cdpa_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  wire  logic [cdpa_pkg::REQ_USER_W-1:0]       req_tuser,
   output logic [cdpa_pkg::RSP_DATA_W-1:0]             rsp_tdata,
   output logic                                        rsp_tuser
);

   cdpa_pkg::mode_type mode_ff, mode_in;
   logic [15:0] count_ff, count_in;
   logic [4:0]  day_ff, day_in;
   logic [3:0]  mon_ff, mon_in;
   logic [15:0] year_ff, year_in;
   logic [8:0]  ymod_ff, ymod_in;
   logic [33:0] prod_ff, prod_in;
   logic [19:0] n_ff, n_in;
   logic        err_ff, err_in;
   logic        feb_ff, feb_in;
   logic [4:0]  out_day_ff, out_day_in;
   logic [3:0]  out_mon_ff, out_mon_in;
   logic [15:0] out_year_ff, out_year_in;
   logic        out_ok_ff, out_ok_in;

   logic        leap_cur, leap_prev;
   logic [4:0]  mlen;
   logic        start_ok, zero_count;
   logic [16:0] count_ext, count_mag;
   logic [16:0] mul_a, mul_b;
   logic [33:0] product;
   logic [8:0]  q400;
   logic [16:0] q400x, ymod_full;
   logic [11:0] q12;
   logic [16:0] q12x, r12_full;
   logic [3:0]  r12, rf;
   logic        neg, rem_nz;
   logic [13:0] q_ext, qf;
   logic [4:0]  nm0, nm_wrap;
   logic        month_wrap;
   logic [3:0]  nm;
   logic [17:0] ny_month, ny_year;
   logic        oob_month, oob_year;
   logic [19:0] count20, delta;
   logic [8:0]  doy;
   logic [19:0] n_init;
   logic [8:0]  ymod_dec, ymod_inc, ylen_cur, ylen_prev;
   logic        n_neg, big_down, big_up, year_fit, month_fit;
   logic [19:0] n_plus_big, n_minus_big;
   logic        snap;

   assign leap_cur  = cdpa_pkg::is_leap(ymod_ff);
   assign mlen      = cdpa_pkg::days_in(mon_ff, leap_cur);
   assign start_ok  = (year_ff != 16'd0) && (mon_ff >= cdpa_pkg::MON_JAN) &&
                      (mon_ff <= cdpa_pkg::MON_DEC) && (day_ff != 5'd0) && (day_ff <= mlen);
   assign zero_count = (count_ff == 16'd0);

   // shared reciprocal multiplier
   assign count_ext = {count_ff[15], count_ff};
   assign count_mag = count_ff[15] ? (~count_ext + 17'd1) : count_ext;
   assign mul_a     = (cmd.op == cdpa_pkg::OP_MUL_COUNT) ? count_mag : {1'b0, year_ff};
   assign mul_b     = (cmd.op == cdpa_pkg::OP_MUL_COUNT) ? cdpa_pkg::RECIP_12
                                                          : cdpa_pkg::RECIP_400;
   assign product   = mul_a * mul_b;

   // year modulo 400
   assign q400      = prod_ff[33:25];
   assign q400x     = {q400, 8'b0} + {1'b0, q400, 7'b0} + {4'b0, q400, 4'b0};
   assign ymod_full = {1'b0, year_ff} - q400x;

   // floor division of the count by 12
   assign q12      = prod_ff[30:19];
   assign q12x     = {2'b0, q12, 3'b0} + {3'b0, q12, 2'b0};
   assign r12_full = count_mag - q12x;
   assign r12      = r12_full[3:0];
   assign neg      = count_ff[15];
   assign rem_nz   = (r12 != 4'd0);
   assign q_ext    = {2'b0, q12};
   assign qf       = neg ? (rem_nz ? ~q_ext : (~q_ext + 14'd1)) : q_ext;
   assign rf       = (neg && rem_nz) ? (4'd12 - r12) : r12;
   assign nm0      = {1'b0, mon_ff - 4'd1} + {1'b0, rf};
   assign month_wrap = (nm0 >= 5'd12);
   assign nm_wrap  = nm0 - 5'd12;
   assign nm       = month_wrap ? nm_wrap[3:0] : nm0[3:0];
   assign ny_month = {2'b0, year_ff} + {{4{qf[13]}}, qf} + {17'b0, month_wrap};
   assign ny_year  = {2'b0, year_ff} + {{2{count_ff[15]}}, count_ff};
   assign oob_month = ny_month[17] || ny_month[16] || (ny_month[15:0] == 16'd0);
   assign oob_year  = ny_year[17] || ny_year[16] || (ny_year[15:0] == 16'd0);

   // day offset within the start year
   assign count20 = {{4{count_ff[15]}}, count_ff};
   assign delta   = (mode_ff == cdpa_pkg::MODE_WEEKS) ? ({count20[16:0], 3'b0} - count20)
                                                      : count20;
   assign doy     = cdpa_pkg::days_before(mon_ff, leap_cur) + {4'b0, day_ff} - 9'd1;
   assign n_init  = {11'b0, doy} + delta;

   // year walk
   assign ymod_dec    = (ymod_ff == 9'd0) ? cdpa_pkg::YMOD_LAST : (ymod_ff - 9'd1);
   assign ymod_inc    = (ymod_ff == cdpa_pkg::YMOD_LAST) ? 9'd0 : (ymod_ff + 9'd1);
   assign leap_prev   = cdpa_pkg::is_leap(ymod_dec);
   assign ylen_cur    = 9'd365 + {8'b0, leap_cur};
   assign ylen_prev   = 9'd365 + {8'b0, leap_prev};
   assign n_neg       = n_ff[19];
   assign n_plus_big  = n_ff + cdpa_pkg::CYCLE_DAYS;
   assign n_minus_big = n_ff - cdpa_pkg::CYCLE_DAYS;
   assign big_down    = n_plus_big[19] || (n_plus_big == 20'd0);
   assign big_up      = !n_minus_big[19];
   assign year_fit    = !n_neg && (n_ff < {11'b0, ylen_cur});
   assign month_fit   = (n_ff < {15'b0, mlen});

   // end-of-month snap for month shifts
   assign snap = (day_ff == 5'd31) || ((day_ff == 5'd29) && leap_cur) ||
                 ((day_ff == 5'd28) && !leap_cur) ||
                 ((day_ff == 5'd30) && (mon_ff != cdpa_pkg::MON_FEB)) ||
                 (((day_ff == 5'd28) || (day_ff == 5'd29)) && feb_ff);

   always_comb begin
      mode_in     = mode_ff;
      count_in    = count_ff;
      day_in      = day_ff;
      mon_in      = mon_ff;
      year_in     = year_ff;
      ymod_in     = ymod_ff;
      prod_in     = prod_ff;
      n_in        = n_ff;
      err_in      = err_ff;
      feb_in      = feb_ff;
      out_day_in  = out_day_ff;
      out_mon_in  = out_mon_ff;
      out_year_in = out_year_ff;
      out_ok_in   = out_ok_ff;
      case (cmd.op)
         cdpa_pkg::OP_LOAD: begin
            mode_in  = cdpa_pkg::mode_type'(req_tuser[1:0]);
            count_in = req_tdata[15:0];
            day_in   = req_tdata[20:16];
            mon_in   = req_tdata[24:21];
            year_in  = req_tdata[40:25];
            err_in   = 1'b0;
            feb_in   = (req_tdata[24:21] == cdpa_pkg::MON_FEB);
         end
         cdpa_pkg::OP_MUL_YEAR, cdpa_pkg::OP_MUL_COUNT: begin
            prod_in = product;
         end
         cdpa_pkg::OP_YMOD: begin
            ymod_in = ymod_full[8:0];
         end
         cdpa_pkg::OP_SETUP: begin
            if (!start_ok) begin
               err_in = 1'b1;
            end else if (!zero_count) begin
               case (mode_ff)
                  cdpa_pkg::MODE_DAYS, cdpa_pkg::MODE_WEEKS: begin
                     n_in   = n_init;
                     mon_in = cdpa_pkg::MON_JAN;
                  end
                  cdpa_pkg::MODE_YEARS: begin
                     if (oob_year) begin
                        err_in = 1'b1;
                     end else begin
                        year_in = ny_year[15:0];
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         cdpa_pkg::OP_MDIV: begin
            mon_in = nm + 4'd1;
            if (oob_month) begin
               err_in = 1'b1;
            end else begin
               year_in = ny_month[15:0];
            end
         end
         cdpa_pkg::OP_SNAP: begin
            if (mode_ff == cdpa_pkg::MODE_MONTHS) begin
               if (snap || (day_ff > mlen)) begin
                  day_in = mlen;
               end
            end else if (feb_ff && ((day_ff == 5'd28) || (day_ff == 5'd29))) begin
               day_in = mlen;
            end
         end
         cdpa_pkg::OP_YSTEP: begin
            if (n_neg) begin
               if (year_ff == 16'd1) begin
                  err_in = 1'b1;
               end else if (big_down) begin
                  if (year_ff <= cdpa_pkg::CYCLE_YEARS) begin
                     err_in = 1'b1;
                  end else begin
                     year_in = year_ff - cdpa_pkg::CYCLE_YEARS;
                     n_in    = n_plus_big;
                  end
               end else begin
                  year_in = year_ff - 16'd1;
                  ymod_in = ymod_dec;
                  n_in    = n_ff + {11'b0, ylen_prev};
               end
            end else if (!year_fit) begin
               if (big_up) begin
                  if (year_ff > (cdpa_pkg::YEAR_MAX - cdpa_pkg::CYCLE_YEARS)) begin
                     err_in = 1'b1;
                  end else begin
                     year_in = year_ff + cdpa_pkg::CYCLE_YEARS;
                     n_in    = n_minus_big;
                  end
               end else if (year_ff == cdpa_pkg::YEAR_MAX) begin
                  err_in = 1'b1;
               end else begin
                  year_in = year_ff + 16'd1;
                  ymod_in = ymod_inc;
                  n_in    = n_ff - {11'b0, ylen_cur};
               end
            end
         end
         cdpa_pkg::OP_MSTEP: begin
            if (month_fit) begin
               day_in = n_ff[4:0] + 5'd1;
            end else begin
               n_in   = n_ff - {15'b0, mlen};
               mon_in = mon_ff + 4'd1;
            end
         end
         cdpa_pkg::OP_EMIT: begin
            out_day_in  = err_ff ? 5'd0 : day_ff;
            out_mon_in  = err_ff ? 4'd0 : mon_ff;
            out_year_in = err_ff ? 16'd0 : year_ff;
            out_ok_in   = !err_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      count_ff    <= count_in;
      day_ff      <= day_in;
      mon_ff      <= mon_in;
      year_ff     <= year_in;
      ymod_ff     <= ymod_in;
      prod_ff     <= prod_in;
      n_ff        <= n_in;
      err_ff      <= err_in;
      feb_ff      <= feb_in;
      out_day_ff  <= out_day_in;
      out_mon_ff  <= out_mon_in;
      out_year_ff <= out_year_in;
      out_ok_ff   <= out_ok_in;
   end

   always_comb begin
      sts.start_ok   = start_ok;
      sts.zero_count = zero_count;
      sts.mode       = mode_ff;
      sts.err        = err_ff;
      sts.year_fit   = year_fit;
      sts.month_fit  = month_fit;
   end

   // result fields from the lowest bit: out_day, out_month, out_year
   assign rsp_tdata = {7'b0, out_year_ff, out_mon_ff, out_day_ff};
   // result flag: date_ok
   assign rsp_tuser = out_ok_ff;

   a_ymod_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == cdpa_pkg::OP_YMOD) |=> (ymod_ff <= cdpa_pkg::YMOD_LAST))
      else $error("year modulo out of range");

   a_walk_day: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == cdpa_pkg::OP_MSTEP && month_fit) |=> (day_ff != 5'd0 && day_ff <= mlen))
      else $error("month walk ended on a day outside the month");

   a_snap_day: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == cdpa_pkg::OP_SNAP && !err_ff) |=> (day_ff != 5'd0 && day_ff <= mlen))
      else $error("snapped day outside the target month");

endmodule

`default_nettype wire

// ===== sv/cdpa_ctrl.sv =====
`default_nettype none

module cdpa_ctrl (
   input  wire  logic              clock,
   input  wire  logic              reset,
   input  wire  logic              req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  wire  logic              rsp_tready,
   input  wire  cdpa_pkg::sts_type sts,
   output cdpa_pkg::cmd_type       cmd
);

   typedef enum logic [11:0] {
      S_IDLE  = 12'b0000_0000_0001,
      S_YMUL  = 12'b0000_0000_0010,
      S_YMOD  = 12'b0000_0000_0100,
      S_CHECK = 12'b0000_0000_1000,
      S_CMUL  = 12'b0000_0001_0000,
      S_CDIV  = 12'b0000_0010_0000,
      S_NMUL  = 12'b0000_0100_0000,
      S_NMOD  = 12'b0000_1000_0000,
      S_SNAP  = 12'b0001_0000_0000,
      S_YSTEP = 12'b0010_0000_0000,
      S_MSTEP = 12'b0100_0000_0000,
      S_DONE  = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd.op       = cdpa_pkg::OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = cdpa_pkg::OP_LOAD;
               state_in = S_YMUL;
            end
         end
         S_YMUL: begin
            cmd.op   = cdpa_pkg::OP_MUL_YEAR;
            state_in = S_YMOD;
         end
         S_YMOD: begin
            cmd.op   = cdpa_pkg::OP_YMOD;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.op = cdpa_pkg::OP_SETUP;
            if (!sts.start_ok || sts.zero_count) begin
               state_in = S_DONE;
            end else begin
               case (sts.mode)
                  cdpa_pkg::MODE_MONTHS: state_in = S_CMUL;
                  cdpa_pkg::MODE_YEARS:  state_in = S_NMUL;
                  default:               state_in = S_YSTEP;
               endcase
            end
         end
         S_CMUL: begin
            cmd.op   = cdpa_pkg::OP_MUL_COUNT;
            state_in = S_CDIV;
         end
         S_CDIV: begin
            cmd.op   = cdpa_pkg::OP_MDIV;
            state_in = S_NMUL;
         end
         S_NMUL: begin
            cmd.op   = cdpa_pkg::OP_MUL_YEAR;
            state_in = S_NMOD;
         end
         S_NMOD: begin
            cmd.op   = cdpa_pkg::OP_YMOD;
            state_in = sts.err ? S_DONE : S_SNAP;
         end
         S_SNAP: begin
            cmd.op   = cdpa_pkg::OP_SNAP;
            state_in = S_DONE;
         end
         S_YSTEP: begin
            if (sts.err) begin
               state_in = S_DONE;
            end else if (sts.year_fit) begin
               state_in = S_MSTEP;
            end else begin
               cmd.op = cdpa_pkg::OP_YSTEP;
            end
         end
         S_MSTEP: begin
            cmd.op = cdpa_pkg::OP_MSTEP;
            if (sts.month_fit) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op       = cdpa_pkg::OP_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_YMUL))
      else $error("accepted request did not start the year reduction");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_tvalid && !rsp_tready) |=> (state_ff == S_DONE))
      else $error("new result emitted over a pending one");

   a_bad_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && !sts.start_ok) |=> (state_ff == S_DONE && sts.err))
      else $error("invalid start date not flagged");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

   localparam int N_DIRECTED = 25;
   localparam int N_RANDOM = 750;
   localparam int N_TOTAL = N_DIRECTED + N_RANDOM;
   localparam int unsigned CYCLE_LIMIT = 2_000_000;

   typedef struct packed {
      logic [4:0]  day;
      logic [3:0]  month;
      logic [15:0] year;
      logic        ok;
   } date_rsp_type;

   typedef struct {
      cdpa_pkg::mode_type mode;
      shortint            count;
      logic [4:0]         day;
      logic [3:0]         month;
      logic [15:0]        year;
      bit                 typed;
      date_rsp_type       want;
   } date_req_type;

   localparam date_rsp_type NO_DATE = '0;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [cdpa_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [cdpa_pkg::REQ_USER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [cdpa_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;

   date_rsp_type pending_dates[$];
   int fault_count = 0;
   int unsigned cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   // rows with a typed result are checked against it, the rest against the predictor
   date_req_type directed_rows [N_DIRECTED] = '{
      '{cdpa_pkg::MODE_DAYS, 0, 5'd15, 4'd6, 16'd2024, 1'b1, {5'd15, 4'd6, 16'd2024, 1'b1}},
      '{cdpa_pkg::MODE_DAYS, 1, 5'd31, 4'd12, 16'd65535, 1'b1, NO_DATE},
      '{cdpa_pkg::MODE_DAYS, -1, 5'd1, 4'd1, 16'd1, 1'b1, NO_DATE},
      '{cdpa_pkg::MODE_DAYS, 0, 5'd0, 4'd1, 16'd2000, 1'b1, NO_DATE},
      '{cdpa_pkg::MODE_MONTHS, 5, 5'd30, 4'd2, 16'd2001, 1'b1, NO_DATE},
      '{cdpa_pkg::MODE_YEARS, 3, 5'd29, 4'd2, 16'd1900, 1'b1, NO_DATE},
      '{cdpa_pkg::MODE_WEEKS, 1, 5'd10, 4'd13, 16'd2000, 1'b1, NO_DATE},
      '{cdpa_pkg::MODE_DAYS, 4, 5'd10, 4'd0, 16'd2000, 1'b1, NO_DATE},
      '{cdpa_pkg::MODE_YEARS, 1, 5'd1, 4'd1, 16'd0, 1'b1, NO_DATE},
      '{cdpa_pkg::MODE_DAYS, 1, 5'd28, 4'd2, 16'd2000, 1'b1, {5'd29, 4'd2, 16'd2000, 1'b1}},
      '{cdpa_pkg::MODE_DAYS, 1, 5'd28, 4'd2, 16'd1900, 1'b1, {5'd1, 4'd3, 16'd1900, 1'b1}},
      '{cdpa_pkg::MODE_DAYS, 32767, 5'd1, 4'd1, 16'd1, 1'b0, NO_DATE},
      '{cdpa_pkg::MODE_DAYS, -32768, 5'd31, 4'd12, 16'd65535, 1'b0, NO_DATE},
      '{cdpa_pkg::MODE_WEEKS, 32767, 5'd31, 4'd12, 16'd65535, 1'b1, NO_DATE},
      '{cdpa_pkg::MODE_WEEKS, -32768, 5'd15, 4'd7, 16'd2000, 1'b0, NO_DATE},
      '{cdpa_pkg::MODE_MONTHS, 1, 5'd31, 4'd1, 16'd2023, 1'b1, {5'd28, 4'd2, 16'd2023, 1'b1}},
      '{cdpa_pkg::MODE_MONTHS, 1, 5'd30, 4'd1, 16'd2024, 1'b1, {5'd29, 4'd2, 16'd2024, 1'b1}},
      '{cdpa_pkg::MODE_MONTHS, 1, 5'd29, 4'd1, 16'd2023, 1'b1, {5'd28, 4'd2, 16'd2023, 1'b1}},
      '{cdpa_pkg::MODE_MONTHS, 1, 5'd28, 4'd2, 16'd2023, 1'b1, {5'd31, 4'd3, 16'd2023, 1'b1}},
      '{cdpa_pkg::MODE_MONTHS, 1, 5'd29, 4'd3, 16'd2024, 1'b1, {5'd30, 4'd4, 16'd2024, 1'b1}},
      '{cdpa_pkg::MODE_MONTHS, -32768, 5'd1, 4'd1, 16'd1, 1'b1, NO_DATE},
      '{cdpa_pkg::MODE_MONTHS, 32767, 5'd1, 4'd1, 16'd65535, 1'b1, NO_DATE},
      '{cdpa_pkg::MODE_YEARS, 1, 5'd29, 4'd2, 16'd2024, 1'b1, {5'd28, 4'd2, 16'd2025, 1'b1}},
      '{cdpa_pkg::MODE_YEARS, 32767, 5'd1, 4'd1, 16'd65535, 1'b1, NO_DATE},
      '{cdpa_pkg::MODE_YEARS, -1, 5'd31, 4'd15, 16'd65535, 1'b1, NO_DATE}
   };

   calendar_date_period_add DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic bit leap_year(input longint yr);
      return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
   endfunction

   function automatic longint month_days(input longint mon, input longint yr);
      case (mon)
         2: return leap_year(yr) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default: return 31;
      endcase
   endfunction

   // day 0 is 1 January of year 1
   function automatic longint day_number(input longint d, input longint m, input longint y);
      longint p;
      longint n;
      p = y - 1;
      n = 365 * p + p / 4 - p / 100 + p / 400;
      for (longint k = 1; k < m; k++)
         n += month_days(k, y);
      return n + d - 1;
   endfunction

   function automatic void date_of_number(input longint n, output longint d,
                                          output longint m, output longint y);
      longint q400, q100, q4, q1;
      q400 = n / 146097;
      n = n % 146097;
      q100 = n / 36524;
      // last day of a 400-year cycle
      if (q100 == 4) q100 = 3;
      n -= q100 * 36524;
      q4 = n / 1461;
      n = n % 1461;
      q1 = n / 365;
      if (q1 == 4) q1 = 3;
      n -= q1 * 365;
      y = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
      m = 1;
      while (m < 12 && n >= month_days(m, y)) begin
         n -= month_days(m, y);
         m++;
      end
      d = n + 1;
   endfunction

   function automatic date_rsp_type shift_date(input date_req_type r);
      date_rsp_type res;
      longint d, m, y, cnt, num, total, last;
      bit ok, lp, from_feb;
      d = r.day;
      m = r.month;
      y = r.year;
      cnt = r.count;
      ok = 1'b1;
      if (y < 1 || m < 1 || m > 12 || d < 1 || d > month_days(m, y)) begin
         ok = 1'b0;
      end else if (cnt != 0) begin
         case (r.mode)
            cdpa_pkg::MODE_DAYS, cdpa_pkg::MODE_WEEKS: begin
               num = day_number(d, m, y) +
                     ((r.mode == cdpa_pkg::MODE_WEEKS) ? cnt * 7 : cnt);
               if (num < 0) ok = 1'b0;
               else date_of_number(num, d, m, y);
            end
            cdpa_pkg::MODE_MONTHS: begin
               total = y * 12 + m - 1 + cnt;
               from_feb = (m == 2);
               if (total < 12) begin
                  ok = 1'b0;
               end else begin
                  y = total / 12;
                  m = total % 12 + 1;
                  if (y <= 65535) begin
                     lp = leap_year(y);
                     last = month_days(m, y);
                     // end-of-month snap
                     if (d == 31 || (d == 29 && lp) || (d == 28 && !lp) ||
                         (d == 30 && m != 2) || ((d == 28 || d == 29) && from_feb))
                        d = last;
                     if (d > last) d = last;
                  end
               end
            end
            cdpa_pkg::MODE_YEARS: begin
               y = y + cnt;
               if (y < 1) ok = 1'b0;
               else if (y <= 65535 && m == 2 && (d == 28 || d == 29)) d = month_days(2, y);
            end
            default: ;
         endcase
         if (ok && y > 65535) ok = 1'b0;
      end
      if (!ok) begin
         d = 0;
         m = 0;
         y = 0;
      end
      res.day = d[4:0];
      res.month = m[3:0];
      res.year = y[15:0];
      res.ok = ok;
      return res;
   endfunction

   function automatic date_req_type random_request();
      date_req_type r;
      int pick;
      longint len;
      r.mode = cdpa_pkg::mode_type'($urandom_range(3));
      pick = $urandom_range(99);
      if (pick < 5) r.count = 0;
      else if (pick < 50) r.count = shortint'($urandom_range(80)) - 16'sd40;
      else if (pick < 75) r.count = shortint'($urandom_range(4000)) - 16'sd2000;
      else r.count = shortint'($urandom);
      pick = $urandom_range(99);
      if (pick < 3) r.year = 16'd0;
      else if (pick < 13) r.year = 16'hFFFF - 16'($urandom_range(40));
      else if (pick < 23) r.year = 16'd1 + 16'($urandom_range(40));
      else if (pick < 30) r.year = 16'($urandom_range(1, 163) * 400 - $urandom_range(3) * 100);
      else r.year = 16'($urandom_range(1, 65535));
      if ($urandom_range(99) < 8) r.month = 4'($urandom_range(15));
      else r.month = 4'($urandom_range(1, 12));
      len = month_days(r.month, r.year);
      pick = $urandom_range(99);
      if (pick < 8) r.day = 5'($urandom_range(31));
      else if (pick < 45) r.day = 5'(len - $urandom_range(3));
      else r.day = 5'($urandom_range(1, len));
      r.typed = 1'b0;
      r.want = NO_DATE;
      return r;
   endfunction

   task automatic flag_error(input string msg);
      fault_count++;
      if (fault_count <= 10) $display("error @%0d: %s", cycle_count, msg);
   endtask

   task automatic send_request(input date_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'b0, r.year, r.month, r.day, r.count};
      req_tuser <= r.mode;
      do @(posedge clock); while (!req_tready);
      pending_dates.push_back(r.typed ? r.want : shift_date(r));
   endtask

   always @(posedge clock) begin : rsp_check
      date_rsp_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[4:0], rsp_tdata[8:5], rsp_tdata[24:9], rsp_tuser};
            if (pending_dates.size() == 0) begin
               flag_error($sformatf("unexpected result %0d/%0d/%0d ok=%0b",
                                    got.day, got.month, got.year, got.ok));
            end else begin
               want = pending_dates.pop_front();
               if (got != want)
                  flag_error($sformatf("expected %0d/%0d/%0d ok=%0b, got %0d/%0d/%0d ok=%0b",
                                       want.day, want.month, want.year, want.ok,
                                       got.day, got.month, got.year, got.ok));
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** calendar_date_period_add: FAILED **");
         $finish;
      end
   end

   initial begin
      date_req_type r;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (int idx = 0; idx < N_TOTAL; idx++) begin
         case (idx * 4 / N_TOTAL)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
         endcase
         r = (idx < N_DIRECTED) ? directed_rows[idx] : random_request();
         send_request(r);
      end
      req_tvalid <= 1'b0;
      while (pending_dates.size() != 0) @(posedge clock);
      // a stray extra result would still show up here
      repeat (20) @(posedge clock);
      if (fault_count == 0) begin
         $display("** calendar_date_period_add: PASSED **");
      end else begin
         $display("** calendar_date_period_add: FAILED **");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/cdpa_pkg.sv
sv/cdpa_dp.sv
sv/cdpa_ctrl.sv
sv/calendar_date_period_add.sv
dv/tb.sv
